// ===== design/cmyk_bayer_dither_pixel_macros.svh =====
// Assertion macros for the CMYK Bayer dither block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CMYK_BAYER_DITHER_PIXEL_MACROS_SVH
`define CMYK_BAYER_DITHER_PIXEL_MACROS_SVH

// checked only outside reset
`define CBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cbd_pkg.sv =====
// Shared types, codes and the Bayer table of the CMYK dither block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  localparam int CBD_MAX_WIDTH = 16384;
  localparam int CBD_MAX_ROWS  = 16384;

  typedef enum logic [1:0] {
    FMT_RGB      = 2'd0,
    FMT_GRAY_INV = 2'd1,
    FMT_BLACK8   = 2'd2,
    FMT_BLACK1   = 2'd3
  } fmt_t;

  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_MONO_MODE    = 3'd1;
  localparam logic [2:0] CFG_ROW_PAIRING  = 3'd2;
  localparam logic [2:0] CFG_LINE_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_ROW_TOTAL    = 3'd4;

  localparam logic [1:0] PAIR_ROWS = 2'd2;

  typedef struct packed {
    logic [13:0] column;
    logic [13:0] out_row;
    logic        err;
    logic        emit;
    logic        avg;
    logic        store_wr;
    logic        store_rd;
  } pix_ctl_t;

  localparam logic [3:0] BAYER4 [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  function automatic logic [7:0] bayer_thr(input logic [1:0] row, input logic [1:0] col);
    return {BAYER4[row][col], 4'b1000};
  endfunction

endpackage

`default_nettype wire

// ===== design/cbd_line_store.sv =====
// Line store for row pairing: one 24-bit pixel per column.
// Single port, registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cbd_line_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [23:0]   wr_data,
  output logic      [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/cbd_raster_ctr.sv =====
// Column/row counters and per-beat control: error, pairing, store access.
// Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_raster_ctr
  import cbd_pkg::*;
#(
  parameter int MAX_WIDTH = CBD_MAX_WIDTH,
  parameter int MAX_ROWS  = CBD_MAX_ROWS,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int RW        = $clog2(MAX_ROWS) + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic [14:0]   line_width,
  input  wire logic [14:0]   row_total,
  input  wire logic          paired,
  input  wire fmt_t          fmt,
  output pix_ctl_t           ctl,
  output logic      [CW-1:0] addr
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [16:0]   eff_w, eff_t, row17, col17;
  logic [31:0]   col32, orow32;
  logic          err, last_col, paired8, y0, last_row;

  always_comb begin
    if (line_width == '0) begin
      eff_w = 17'd1;
    end else if (17'(line_width) > 17'(MAX_WIDTH)) begin
      eff_w = 17'(MAX_WIDTH);
    end else begin
      eff_w = 17'(line_width);
    end
    if (17'(row_total) > 17'(MAX_ROWS)) begin
      eff_t = 17'(MAX_ROWS);
    end else begin
      eff_t = 17'(row_total);
    end
  end

  assign row17    = 17'(row_r);
  assign col17    = 17'(col_r);
  assign err      = row17 >= eff_t;
  assign last_col = (col17 + 17'd1) >= eff_w;
  assign last_row = !((row17 + 17'd1) < eff_t);
  assign paired8  = paired && (fmt != FMT_BLACK1);
  assign y0       = row_r[0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance && !err) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col32  = 32'(col_r);
  assign orow32 = paired ? 32'(row_r >> 1) : 32'(row_r);

  always_comb begin
    ctl.column   = err ? '0 : col32[13:0];
    ctl.out_row  = err ? '0 : orow32[13:0];
    ctl.err      = err;
    ctl.store_wr = !err && paired8 && !y0;
    ctl.store_rd = !err && paired8 && y0;
    ctl.avg      = ctl.store_rd;
    ctl.emit     = err || !((paired8 && !y0 && !last_row) || (paired && !paired8 && y0));
  end

  assign addr = col_r;

endmodule

`default_nettype wire

// ===== design/cbd_dither.sv =====
// Pixel to CMYK levels (pair averaging, gray removal, luminance) and
// Bayer threshold compare. Combinational. Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_dither
  import cbd_pkg::*;
(
  input  wire pix_ctl_t   ctl,
  input  wire fmt_t       fmt,
  input  wire logic       mono,
  input  wire logic [7:0] sample_a,
  input  wire logic [7:0] sample_b,
  input  wire logic [7:0] sample_c,
  input  wire logic [23:0] stored,
  output logic      [3:0] dots       // {black, yellow, magenta, cyan}
);

  logic [8:0]  sum_a, sum_b, sum_c;
  logic [7:0]  pa, pb, pc;
  logic [15:0] lum;
  logic [7:0]  ic, im, iy, k;
  logic [7:0]  vc, vm, vy, vk;
  logic [7:0]  thr;

  assign sum_a = 9'(stored[23:16]) + 9'(sample_a) + 9'd1;
  assign sum_b = 9'(stored[15:8])  + 9'(sample_b) + 9'd1;
  assign sum_c = 9'(stored[7:0])   + 9'(sample_c) + 9'd1;
  assign pa = ctl.avg ? sum_a[8:1] : sample_a;
  assign pb = ctl.avg ? sum_b[8:1] : sample_b;
  assign pc = ctl.avg ? sum_c[8:1] : sample_c;

  assign lum = 16'(pa) * 16'd77 + 16'(pb) * 16'd150 + 16'(pc) * 16'd29 + 16'd128;

  assign ic = ~pa;
  assign im = ~pb;
  assign iy = ~pc;

  always_comb begin
    k = (ic < im) ? ic : im;
    if (iy < k) begin
      k = iy;
    end
  end

  always_comb begin
    vc = '0;
    vm = '0;
    vy = '0;
    vk = '0;
    case (fmt)
      FMT_RGB: begin
        if (mono) begin
          vk = ~lum[15:8];
        end else begin
          vc = ic - k;
          vm = im - k;
          vy = iy - k;
          vk = k;
        end
      end
      FMT_GRAY_INV: vk = ~pa;
      FMT_BLACK8:   vk = pa;
      default:      vk = {8{pa[0]}};
    endcase
  end

  assign thr = bayer_thr(ctl.out_row[1:0], ctl.column[1:0]);

  assign dots = ctl.err ? 4'b0000 : {vk > thr, vy > thr, vm > thr, vc > thr};

endmodule

`default_nettype wire

// ===== design/cmyk_bayer_dither_pixel.sv =====
// Ordered 4x4 Bayer dither of a raster pixel stream into four CMYK dot bits.
// The block counts column and row itself from line_width and input_row_total.
// It takes one pixel per clock. A pixel and its line store read are registered when
// the pixel is accepted; its dot beat is registered in the output stage once that
// stage is free. The input stalls only while both stages hold a beat and out_tready
// is low. Even rows in paired 8-bit mode, but the last, and odd rows in paired 1-bit
// mode produce no beat. Pixels past the row total give one beat with out_tuser set
// and zero data; only reset starts a new page. The line store is not cleared:
// reading a column on an odd row that the even row never wrote gives undefined dots.
// The user must write configuration only while idle; the block does not enforce it.
// Depends on cbd_pkg, cbd_raster_ctr, cbd_line_store, cbd_dither.
`timescale 1ns / 1ps
`default_nettype none

`include "cmyk_bayer_dither_pixel_macros.svh"

module cmyk_bayer_dither_pixel
  import cbd_pkg::*;
#(
  parameter int MAX_WIDTH = CBD_MAX_WIDTH,
  parameter int MAX_ROWS  = CBD_MAX_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // sample_a, sample_b, sample_c
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // column, out_row, cyan, magenta, yellow, black
  output logic             out_tuser,  // order_error
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_ROWS) + 1;

  fmt_t        fmt_r, fmt_nxt;
  logic        mono_r, mono_nxt;
  logic [1:0]  pair_r, pair_nxt;
  logic [14:0] width_r, width_nxt;
  logic [14:0] rows_r, rows_nxt;

  logic          accept, out_free, s1_go;
  pix_ctl_t      ctl;
  logic [CW-1:0] addr;
  logic [23:0]   rd_data;
  logic [3:0]    dots;

  logic        s1_valid_r, s1_valid_nxt;
  pix_ctl_t    s1_ctl_r;
  logic [23:0] s1_px_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_err_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    fmt_nxt   = fmt_r;
    mono_nxt  = mono_r;
    pair_nxt  = pair_r;
    width_nxt = width_r;
    rows_nxt  = rows_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: fmt_nxt   = fmt_t'(cfg_data[1:0]);
        CFG_MONO_MODE:    mono_nxt  = cfg_data[0];
        CFG_ROW_PAIRING:  pair_nxt  = cfg_data[1:0];
        CFG_LINE_WIDTH:   width_nxt = cfg_data[14:0];
        CFG_ROW_TOTAL:    rows_nxt  = cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_RGB;
      mono_r  <= 1'b0;
      pair_r  <= 2'd1;
      width_r <= 15'd1;
      rows_r  <= 15'd1;
    end else begin
      fmt_r   <= fmt_nxt;
      mono_r  <= mono_nxt;
      pair_r  <= pair_nxt;
      width_r <= width_nxt;
      rows_r  <= rows_nxt;
    end
  end

  // two-stage pipe: stage 1 waits on the line store read, stage 2 is the output
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = !s1_valid_r || out_free;
  assign in_tready = s1_go;
  assign accept    = in_tvalid && in_tready;

  cbd_raster_ctr #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS),
    .CW        (CW),
    .RW        (RW)
  ) u_ctr (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .line_width (width_r),
    .row_total  (rows_r),
    .paired     (pair_r == PAIR_ROWS),
    .fmt        (fmt_r),
    .ctl        (ctl),
    .addr       (addr)
  );

  cbd_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && ctl.store_wr),
    .rd_en   (accept && ctl.store_rd),
    .addr    (addr),
    .wr_data ({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}),
    .rd_data (rd_data)
  );

  cbd_dither u_dither (
    .ctl      (s1_ctl_r),
    .fmt      (fmt_r),
    .mono     (mono_r),
    .sample_a (s1_px_r[7:0]),
    .sample_b (s1_px_r[15:8]),
    .sample_c (s1_px_r[23:16]),
    .stored   (rd_data),
    .dots     (dots)
  );

  assign s1_valid_nxt  = s1_go ? accept : s1_valid_r;
  assign out_valid_nxt = out_free ? (s1_valid_r && s1_ctl_r.emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl;
      s1_px_r  <= in_tdata;
    end
    if (out_free && s1_valid_r) begin
      out_data_r <= {dots, s1_ctl_r.out_row, s1_ctl_r.column};
      out_err_r  <= s1_ctl_r.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  `CBD_ASSERT(a_err_zero, out_tvalid && out_tuser |-> out_tdata == 32'd0, "error beat carries data")
  `CBD_ASSERT(a_no_overrun, s1_valid_r && out_valid_r && !out_tready |-> !in_tready, "accept while pipe full")
  `CBD_ASSERT(a_err_emits, s1_valid_r && s1_ctl_r.err |-> s1_ctl_r.emit, "error pixel dropped")
  `CBD_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid && !s1_valid_r, "pipe not empty after reset")

endmodule

`default_nettype wire
